// File: rtl/fmprc_pkg.sv
`timescale 1ns / 1ps

package fmprc_pkg;

	localparam int RULE_DEPTH_DEF = 16;
	localparam int GRP_W          = 16;

	localparam logic [7:0] PROTO_TCP = 8'd6;
	localparam logic [7:0] PROTO_UDP = 8'd17;

	typedef enum logic [1:0] {
		MODE_WRITE    = 2'd0,
		MODE_CLASSIFY = 2'd1,
		MODE_PORT     = 2'd2,
		MODE_UNUSED   = 2'd3
	} mode_t;

	typedef struct packed {
		mode_t       mode;
		logic [3:0]  rule_index;
		logic [31:0] src_addr;
		logic [31:0] dst_addr;
		logic [15:0] dst_port;
		logic [7:0]  proto_field;
		logic [7:0]  rule_action;
	} req_t;

	typedef struct packed {
		logic [7:0] action;
		logic       hit;
		logic [3:0] hit_index;
	} res_t;

endpackage

// File: rtl/first_match_packet_rule_classifier_unit.sv
`timescale 1ns / 1ps

// First-match rule classifier.
// Request channel: req is transferred at a clock edge with start high and busy low.
// busy is never raised, so one request may be transferred in every cycle.
// Mode 0 stores a rule at rule_index; mode 3 is dropped. Neither gives a result.
// Modes 1 (header classify) and 2 (port-only lookup) each give exactly one
// result: res_valid is high for one cycle.
// Pipeline: input register, parallel compare of every rule, per-group first
// hit over groups of 16 rules, group select, action read into the result
// register. Throughput is one request per cycle, as busy is never raised.
// A rule write is visible to any request transferred after it.
// Configuration: cfg_data (active_rules) is written when cfg_valid and
// cfg_ready are high; cfg_ready is always high. Write only while idle.
// Reset clears active_rules and all pipeline valid bits; the rule table is
// not cleared and must be written before it is searched.
// The receiver cannot stall: each result is on res for that one cycle only.
module first_match_packet_rule_classifier_unit
	import fmprc_pkg::*;
#(
	parameter int RULE_DEPTH = RULE_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  req_t       req,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [4:0] cfg_data,
	output logic       res_valid,
	output res_t       res
);

	localparam int IDX_W = (RULE_DEPTH > 1) ? $clog2(RULE_DEPTH) : 1;
	localparam int GRP   = (RULE_DEPTH + GRP_W - 1) / GRP_W;
	localparam int PAD   = GRP * GRP_W;

	logic [4:0]  active_rules_q;

	logic [31:0] src_tbl_q  [RULE_DEPTH];
	logic [31:0] dst_tbl_q  [RULE_DEPTH];
	logic [15:0] port_tbl_q [RULE_DEPTH];
	logic [7:0]  mask_tbl_q [RULE_DEPTH];
	logic [7:0]  act_tbl_q  [RULE_DEPTH];

	logic        v_s1;
	req_t        req_s1;

	logic        lk_s2, wr_s2;
	logic [PAD-1:0] match_s2;
	logic [IDX_W-1:0] wr_idx_s2;
	logic [7:0]  wr_act_s2;

	logic        lk_s3, wr_s3;
	logic [GRP-1:0] ghit_s3;
	logic [3:0]  gidx_s3 [GRP];
	logic [IDX_W-1:0] wr_idx_s3;
	logic [7:0]  wr_act_s3;

	logic        lk_s4, wr_s4;
	logic        hit_s4;
	logic [IDX_W-1:0] idx_s4;
	logic [IDX_W-1:0] wr_idx_s4;
	logic [7:0]  wr_act_s4;

	logic        res_valid_q;
	res_t        res_q;

	logic        accept;
	logic        lk_s1, wr_s1, tcp_udp_s1, port_mode_s1;
	logic [IDX_W-1:0] wr_idx_s1;
	logic [PAD-1:0] match_c;
	logic [GRP-1:0] ghit_c;
	logic [3:0]  gidx_c [GRP];
	logic        hit_c;
	logic [IDX_W-1:0] idx_c;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_rules_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			active_rules_q <= cfg_data;
		end
	end

	// stage 1: input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1 <= req;
		end
	end

	assign lk_s1 = v_s1 && (req_s1.mode == MODE_CLASSIFY || req_s1.mode == MODE_PORT);
	assign wr_s1 = v_s1 && (req_s1.mode == MODE_WRITE) &&
		(32'(req_s1.rule_index) < 32'(RULE_DEPTH));
	assign wr_idx_s1    = IDX_W'(req_s1.rule_index);
	assign port_mode_s1 = (req_s1.mode == MODE_PORT);
	assign tcp_udp_s1   = (req_s1.proto_field == PROTO_TCP) ||
		(req_s1.proto_field == PROTO_UDP);

	// match tables are written and read in stage 1
	always_ff @(posedge clk) begin
		if (wr_s1) begin
			src_tbl_q[wr_idx_s1]  <= req_s1.src_addr;
			dst_tbl_q[wr_idx_s1]  <= req_s1.dst_addr;
			port_tbl_q[wr_idx_s1] <= req_s1.dst_port;
			mask_tbl_q[wr_idx_s1] <= req_s1.proto_field;
		end
	end

	for (genvar k = 0; k < PAD; k++) begin : g_cmp
		if (k < RULE_DEPTH) begin : g_rule
			logic port_eq, addr_eq, mask_ok;
			assign port_eq = (port_tbl_q[k] == req_s1.dst_port);
			assign addr_eq = (src_tbl_q[k] == req_s1.src_addr) &&
				(dst_tbl_q[k] == req_s1.dst_addr);
			assign mask_ok = |(mask_tbl_q[k] & req_s1.proto_field);
			assign match_c[k] = (k < int'(active_rules_q)) &&
				(port_mode_s1 ? port_eq : (addr_eq && mask_ok && (!tcp_udp_s1 || port_eq)));
		end else begin : g_pad
			assign match_c[k] = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lk_s2 <= 1'b0;
			wr_s2 <= 1'b0;
		end else begin
			lk_s2 <= lk_s1;
			wr_s2 <= wr_s1;
		end
	end

	always_ff @(posedge clk) begin
		match_s2  <= match_c;
		wr_idx_s2 <= wr_idx_s1;
		wr_act_s2 <= req_s1.rule_action;
	end

	// stage 2: first hit within each group
	always_comb begin
		for (int g = 0; g < GRP; g++) begin
			ghit_c[g] = |match_s2[g*GRP_W +: GRP_W];
			gidx_c[g] = '0;
			for (int j = GRP_W - 1; j >= 0; j--) begin
				if (match_s2[g*GRP_W + j]) begin
					gidx_c[g] = 4'(j);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lk_s3 <= 1'b0;
			wr_s3 <= 1'b0;
		end else begin
			lk_s3 <= lk_s2;
			wr_s3 <= wr_s2;
		end
	end

	always_ff @(posedge clk) begin
		ghit_s3   <= ghit_c;
		gidx_s3   <= gidx_c;
		wr_idx_s3 <= wr_idx_s2;
		wr_act_s3 <= wr_act_s2;
	end

	// stage 3: first group with a hit
	always_comb begin
		hit_c = 1'b0;
		idx_c = '0;
		for (int g = GRP - 1; g >= 0; g--) begin
			if (ghit_s3[g]) begin
				hit_c = 1'b1;
				idx_c = IDX_W'(g * GRP_W + int'(gidx_s3[g]));
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lk_s4 <= 1'b0;
			wr_s4 <= 1'b0;
		end else begin
			lk_s4 <= lk_s3;
			wr_s4 <= wr_s3;
		end
	end

	always_ff @(posedge clk) begin
		hit_s4    <= hit_c;
		idx_s4    <= idx_c;
		wr_idx_s4 <= wr_idx_s3;
		wr_act_s4 <= wr_act_s3;
	end

	// stage 4: action table written and read here, keeping order with the lookups
	always_ff @(posedge clk) begin
		if (wr_s4) begin
			act_tbl_q[wr_idx_s4] <= wr_act_s4;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else begin
			res_valid_q <= lk_s4;
		end
	end

	always_ff @(posedge clk) begin
		res_q.hit       <= hit_s4;
		res_q.hit_index <= hit_s4 ? 4'(idx_s4) : 4'd0;
		res_q.action    <= hit_s4 ? act_tbl_q[idx_s4] : 8'd0;
	end

	a_lookup_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (req.mode == MODE_CLASSIFY || req.mode == MODE_PORT)) |-> ##5 res_valid)
		else $error("lookup transfer gave no result");

	a_write_gives_none: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (req.mode == MODE_WRITE || req.mode == MODE_UNUSED)) |-> ##5 !res_valid)
		else $error("result from a write or unused request");

	a_miss_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res.hit) |-> (res.action == 8'd0 && res.hit_index == 4'd0))
		else $error("miss carries non-zero action or index");

	a_stage_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(lk_s4 && wr_s4) && !(lk_s2 && wr_s2))
		else $error("write and lookup share a stage");

endmodule

// File: bench/tb_first_match_packet_rule_classifier_unit.sv
`timescale 1ns / 1ps

module tb_first_match_packet_rule_classifier_unit
	import fmprc_pkg::*;
;

	localparam int DEPTH       = RULE_DEPTH_DEF;
	localparam int CYCLE_LIMIT = 200000;
	localparam int SETTLE      = 8;

	logic       clk;
	logic       arst_n    = 1'b0;
	logic       start     = 1'b0;
	logic       busy;
	req_t       req       = '0;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [4:0] cfg_data  = '0;
	logic       res_valid;
	res_t       res;

	first_match_packet_rule_classifier_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.req       (req),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.res_valid (res_valid),
		.res       (res)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// rule table as seen through accepted transfers
	logic [31:0] rule_src  [DEPTH];
	logic [31:0] rule_dst  [DEPTH];
	logic [15:0] rule_port [DEPTH];
	logic [7:0]  rule_mask [DEPTH];
	logic [7:0]  rule_act  [DEPTH];
	logic [4:0]  rule_limit = '0;

	req_t        request_q [$];
	res_t        verdict_q [$];
	int          idle_pct = 0;
	int          mismatch_count = 0;
	int          cycle_count = 0;

	logic [31:0] src_pool  [4];
	logic [31:0] dst_pool  [4];
	logic [15:0] port_pool [4];

	function automatic res_t lookup_verdict(req_t r);
		res_t v;
		int   n;
		logic m;
		v = '0;
		n = (int'(rule_limit) > DEPTH) ? DEPTH : int'(rule_limit);
		// walk downwards so the lowest matching index is left standing
		for (int k = n - 1; k >= 0; k--) begin
			if (r.mode == MODE_PORT) begin
				m = (rule_port[k] == r.dst_port);
			end else begin
				m = (rule_src[k] == r.src_addr) && (rule_dst[k] == r.dst_addr) &&
					((r.proto_field & rule_mask[k]) != 8'd0);
				if ((r.proto_field == PROTO_TCP || r.proto_field == PROTO_UDP) &&
					rule_port[k] != r.dst_port)
					m = 1'b0;
			end
			if (m) begin
				v.action    = rule_act[k];
				v.hit       = 1'b1;
				v.hit_index = 4'(k);
			end
		end
		return v;
	endfunction

	function automatic void record_transfer(req_t r);
		case (r.mode)
			MODE_WRITE: begin
				if (int'(r.rule_index) < DEPTH) begin
					rule_src[r.rule_index]  = r.src_addr;
					rule_dst[r.rule_index]  = r.dst_addr;
					rule_port[r.rule_index] = r.dst_port;
					rule_mask[r.rule_index] = r.proto_field;
					rule_act[r.rule_index]  = r.rule_action;
				end
			end
			MODE_CLASSIFY, MODE_PORT: begin
				verdict_q.push_back(lookup_verdict(r));
			end
			default: begin
			end
		endcase
	endfunction

	function automatic req_t mk(mode_t mode, logic [3:0] idx, logic [31:0] src,
			logic [31:0] dst, logic [15:0] port, logic [7:0] proto, logic [7:0] act);
		req_t r;
		r.mode        = mode;
		r.rule_index  = idx;
		r.src_addr    = src;
		r.dst_addr    = dst;
		r.dst_port    = port;
		r.proto_field = proto;
		r.rule_action = act;
		return r;
	endfunction

	function automatic logic [7:0] pick_proto();
		case ($urandom_range(0, 5))
			0: return PROTO_TCP;
			1: return PROTO_UDP;
			2: return 8'd0;
			3: return 8'hFF;
			4: return 8'd1;
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic logic [7:0] pick_mask();
		case ($urandom_range(0, 4))
			0: return 8'hFF;
			1: return 8'h00;
			2: return PROTO_TCP | PROTO_UDP;
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic req_t random_request();
		req_t         r;
		logic [127:0] raw;
		int           pick;
		raw  = {$urandom, $urandom, $urandom, $urandom};
		r    = raw[$bits(req_t)-1:0];
		pick = $urandom_range(0, 99);
		if (pick < 20) begin
			r = mk(MODE_WRITE, 4'($urandom), src_pool[$urandom_range(0, 3)],
				dst_pool[$urandom_range(0, 3)], port_pool[$urandom_range(0, 3)],
				pick_mask(), ($urandom_range(0, 9) == 0) ? 8'd0 : 8'($urandom));
		end else if (pick < 75) begin
			r.mode        = MODE_CLASSIFY;
			r.src_addr    = src_pool[$urandom_range(0, 3)];
			r.dst_addr    = dst_pool[$urandom_range(0, 3)];
			r.dst_port    = port_pool[$urandom_range(0, 3)];
			r.proto_field = pick_proto();
		end else if (pick < 90) begin
			r.mode     = MODE_PORT;
			r.dst_port = port_pool[$urandom_range(0, 3)];
		end else if (pick >= 96) begin
			r.mode = MODE_UNUSED;
		end
		return r;
	endfunction

	task automatic report(string what, logic [7:0] want, logic [7:0] got);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("mismatch on %s: expected %0h, got %0h", what, want, got);
	endtask

	task automatic settle();
		do @(posedge clk);
		while (request_q.size() != 0 || start || verdict_q.size() != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_rule_limit(logic [4:0] n);
		cfg_valid <= 1'b1;
		cfg_data  <= n;
		do @(posedge clk);
		while (cfg_ready !== 1'b1);
		rule_limit = n;
		cfg_valid  <= 1'b0;
	endtask

	// request driver
	always @(posedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
			req   <= '0;
		end else begin
			if (start && busy === 1'b0)
				record_transfer(req);
			if (!start || busy === 1'b0) begin
				if (request_q.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
					req   <= request_q.pop_front();
					start <= 1'b1;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk) begin : result_check
		res_t want;
		if (arst_n && res_valid === 1'b1) begin
			if (verdict_q.size() == 0) begin
				report("result with none pending", 8'd0, res.action);
			end else begin
				want = verdict_q.pop_front();
				if (res.action !== want.action)
					report("action", want.action, res.action);
				if (res.hit !== want.hit)
					report("hit", 8'(want.hit), 8'(res.hit));
				if (res.hit_index !== want.hit_index)
					report("hit_index", 8'(want.hit_index), 8'(res.hit_index));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("first_match_packet_rule_classifier_unit verification failed");
			$finish;
		end
	end

	initial begin
		logic [4:0] limits [5];
		int         counts [5];
		int         idles  [5];
		limits = '{5'd31, 5'd16, 5'd0, 5'd9, 5'd1};
		counts = '{130, 110, 30, 130, 50};
		idles  = '{9, 81, 81, 0, 0};
		src_pool  = '{32'h0, 32'hFFFF_FFFF, 32'hC0A8_0001, $urandom};
		dst_pool  = '{32'h0, 32'hFFFF_FFFF, 32'h0A00_0001, $urandom};
		port_pool = '{16'h0, 16'hFFFF, 16'd80, 16'd443};

		repeat (11) @(posedge clk);
		arst_n   <= 1'b1;
		idle_pct = 9;

		// nothing searched straight after reset
		request_q.push_back(mk(MODE_CLASSIFY, 4'd0, 32'h0, 32'h0, 16'h0, 8'd1, 8'd0));
		request_q.push_back(mk(MODE_WRITE, 4'd0, 32'h0, 32'h0, 16'h0, 8'hFF, 8'h00));
		request_q.push_back(mk(MODE_WRITE, 4'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF,
			8'h80, 8'hFF));
		request_q.push_back(mk(MODE_WRITE, 4'd2, 32'hC0A8_0001, 32'h0A00_0001, 16'd80,
			8'h04, 8'h21));
		request_q.push_back(mk(MODE_WRITE, 4'd3, 32'hC0A8_0001, 32'h0A00_0001, 16'd443,
			8'h11, 8'h22));
		request_q.push_back(mk(MODE_WRITE, 4'd4, 32'hC0A8_0001, 32'h0A00_0001, 16'd53,
			8'h02, 8'h23));
		request_q.push_back(mk(MODE_WRITE, 4'd5, 32'hC0A8_0001, 32'h0A00_0001, 16'd80,
			8'h04, 8'h55));
		settle();
		set_rule_limit(5'd6);

		// matching rule with action zero, port ignored off TCP/UDP
		request_q.push_back(mk(MODE_CLASSIFY, 4'd0, 32'h0, 32'h0, 16'd1234, 8'd1, 8'd0));
		request_q.push_back(mk(MODE_CLASSIFY, 4'd0, 32'h0, 32'h0, 16'h0, PROTO_TCP, 8'd0));
		request_q.push_back(mk(MODE_CLASSIFY, 4'd0, 32'h0, 32'h0, 16'd5, PROTO_TCP, 8'd0));
		request_q.push_back(mk(MODE_CLASSIFY, 4'd0, 32'h0, 32'h0, 16'h0, 8'd0, 8'd0));
		request_q.push_back(mk(MODE_CLASSIFY, 4'hF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h0,
			8'hFF, 8'hFF));
		// shadowed duplicate at a higher index
		request_q.push_back(mk(MODE_CLASSIFY, 4'd0, 32'hC0A8_0001, 32'h0A00_0001, 16'd80,
			PROTO_TCP, 8'd0));
		request_q.push_back(mk(MODE_CLASSIFY, 4'd0, 32'hC0A8_0001, 32'h0A00_0001, 16'd443,
			PROTO_UDP, 8'd0));
		request_q.push_back(mk(MODE_CLASSIFY, 4'd0, 32'hC0A8_0001, 32'h0A00_0001, 16'd80,
			PROTO_UDP, 8'd0));
		request_q.push_back(mk(MODE_CLASSIFY, 4'd0, 32'hC0A8_0001, 32'h0A00_0001, 16'd9999,
			8'd2, 8'd0));
		request_q.push_back(mk(MODE_PORT, 4'd0, 32'h0, 32'h0, 16'd80, 8'd0, 8'd0));
		request_q.push_back(mk(MODE_PORT, 4'd0, 32'h0, 32'h0, 16'h0, 8'd0, 8'd0));
		request_q.push_back(mk(MODE_PORT, 4'd0, 32'h0, 32'h0, 16'd8080, 8'd0, 8'd0));
		request_q.push_back(mk(MODE_UNUSED, 4'd2, 32'h1, 32'h2, 16'd80, 8'hFF, 8'h99));
		request_q.push_back(mk(MODE_CLASSIFY, 4'd0, 32'hC0A8_0001, 32'h0A00_0001, 16'd80,
			PROTO_TCP, 8'd0));
		settle();

		for (int i = 6; i < DEPTH - 1; i++)
			request_q.push_back(random_request());
		for (int i = 6; i < DEPTH - 1; i++)
			request_q.push_back(mk(MODE_WRITE, 4'(i), src_pool[$urandom_range(0, 3)],
				dst_pool[$urandom_range(0, 3)], port_pool[$urandom_range(0, 3)],
				pick_mask(), 8'($urandom)));
		request_q.push_back(mk(MODE_WRITE, 4'hF, 32'h1234_5678, 32'h9ABC_DEF0, 16'd8080,
			8'hFF, 8'h7F));
		settle();

		for (int p = 0; p < 5; p++) begin
			set_rule_limit(limits[p]);
			idle_pct = idles[p];
			// search beyond the table depth saturates at the last entry
			if (p == 0)
				request_q.push_back(mk(MODE_CLASSIFY, 4'd0, 32'h1234_5678, 32'h9ABC_DEF0,
					16'd8080, PROTO_TCP, 8'd0));
			for (int i = 0; i < counts[p]; i++)
				request_q.push_back(random_request());
			settle();
		end

		if (mismatch_count == 0) begin
			$display("first_match_packet_rule_classifier_unit verification clean");
		end else begin
			$display("first_match_packet_rule_classifier_unit verification failed");
		end
		$finish;
	end

endmodule
